@@ design/mpm_pkg.sv @@
// ----------------------------------------------------------------------------
// mpm_pkg: shared types and constants of the one-mismatch pattern matcher
// Sizes of the pattern store and the text window, item codes and the row
// compare function used by the back end.
// ----------------------------------------------------------------------------
package mpm_pkg;

  localparam int PATTERN_BYTES = 64;
  localparam int MAX_PATTERNS  = 256;
  localparam int ROW_W         = PATTERN_BYTES * 8;
  localparam int ROW_AW        = $clog2(MAX_PATTERNS);
  localparam int POS_W         = $clog2(PATTERN_BYTES);
  localparam int FILL_W        = $clog2(PATTERN_BYTES + 1);
  localparam int CNT_W         = $clog2(MAX_PATTERNS + 1);
  localparam int TOTAL_W       = 48;
  localparam int KIND_W        = 2;
  localparam int BYTE_W        = 8;
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_AW       = $clog2(FIFO_DEPTH);
  localparam int APB_DW        = 32;
  localparam int APB_AW        = 3;

  localparam logic [FILL_W-1:0]  FILL_FULL = FILL_W'(PATTERN_BYTES);
  localparam logic [CNT_W-1:0]   CNT_MAX   = CNT_W'(MAX_PATTERNS);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // Input item codes
  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TEXT  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  // Register index of pattern_count
  localparam logic REG_PATTERN_COUNT = 1'b0;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_TEXT,
    OP_CLEAR
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [ROW_AW-1:0] pattern_index;
    logic [POS_W-1:0]  byte_position;
    logic [BYTE_W-1:0] data_byte;
  } cmd_t;

  // True when the two rows differ in at most one byte
  function automatic logic within_one(input logic [ROW_W-1:0] a,
                                      input logic [ROW_W-1:0] b);
    logic [PATTERN_BYTES-1:0] diff;
    for (int j = 0; j < PATTERN_BYTES; j++) begin
      diff[j] = (a[j*8 +: 8] != b[j*8 +: 8]);
    end
    return ((diff & (diff - PATTERN_BYTES'(1))) == '0);
  endfunction

endpackage

@@ design/mpm_if.sv @@
// ----------------------------------------------------------------------------
// mpm_if: valid/ready channels of the matcher
// Input item channel and result channel, each with source and sink modports.
// ----------------------------------------------------------------------------
interface mpm_in_if
  import mpm_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [ROW_AW-1:0] pattern_index;
  logic [POS_W-1:0]  byte_position;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, kind, pattern_index, byte_position, data_byte,
                  input ready);
  modport sink   (input valid, kind, pattern_index, byte_position, data_byte,
                  output ready);
endinterface

interface mpm_out_if
  import mpm_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [CNT_W-1:0]   window_matches;
  logic [TOTAL_W-1:0] running_total;

  modport source (output valid, window_matches, running_total, input ready);
  modport sink   (input valid, window_matches, running_total, output ready);
endinterface

@@ design/mpm_front.sv @@
// ----------------------------------------------------------------------------
// mpm_front: item intake and command queue
// Classifies input items into commands, drops unused codes and buffers the
// commands in a short queue toward the back end.
// ----------------------------------------------------------------------------
module mpm_front
  import mpm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [KIND_W-1:0] kind_i,
  input  logic [ROW_AW-1:0] pattern_index_i,
  input  logic [POS_W-1:0]  byte_position_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output cmd_t              cmd_o
);

  cmd_t               fifo_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_AW:0]   count_q, count_d;
  logic               keep;
  logic               push;
  logic               pop;
  cmd_t               cmd_new;

  // Classify the incoming item; the unused code is dropped
  always_comb begin
    keep            = 1'b1;
    cmd_new.op      = OP_LOAD;
    case (kind_i)
      KIND_LOAD:  cmd_new.op = OP_LOAD;
      KIND_TEXT:  cmd_new.op = OP_TEXT;
      KIND_CLEAR: cmd_new.op = OP_CLEAR;
      default:    keep = 1'b0;
    endcase
    cmd_new.pattern_index = pattern_index_i;
    cmd_new.byte_position = byte_position_i;
    cmd_new.data_byte     = data_byte_i;
  end

  assign in_ready_o  = (count_q != (FIFO_AW + 1)'(FIFO_DEPTH));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = fifo_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o && keep;
  assign pop         = cmd_valid_o && cmd_ready_i;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + FIFO_AW'(1) : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + FIFO_AW'(1) : rd_ptr_q;
    count_d  = count_q + (FIFO_AW + 1)'(push) - (FIFO_AW + 1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store queue entries
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

@@ design/mpm_back.sv @@
// ----------------------------------------------------------------------------
// mpm_back: pattern store, text window and scan engine
// Executes one command at a time: writes pattern bytes, clears the window and
// total, shifts text bytes in, scans one row per cycle against a full window.
// ----------------------------------------------------------------------------
module mpm_back
  import mpm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  output logic               cmd_ready_o,
  input  cmd_t               cmd_i,
  input  logic [CNT_W-1:0]   pattern_count_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [CNT_W-1:0]   window_matches_o,
  output logic [TOTAL_W-1:0] running_total_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  logic [ROW_W-1:0]   mem [MAX_PATTERNS];
  logic [ROW_W-1:0]   rdata_q;
  logic               rd_valid_q;
  logic [ROW_W-1:0]   win_q, win_d;
  logic [FILL_W-1:0]  fill_q, fill_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic [CNT_W-1:0]   hits_q, hits_d;
  logic [CNT_W-1:0]   k_q, k_d;
  logic [CNT_W-1:0]   limit;
  logic [TOTAL_W:0]   total_sum;
  logic [TOTAL_W-1:0] total_new;
  logic               out_valid_q;
  logic [CNT_W-1:0]   out_win_q;
  logic [TOTAL_W-1:0] out_total_q;
  logic               out_free;
  logic               pop;
  logic               mem_we;
  logic [FILL_W-1:0]  fill_inc;

  assign limit    = (pattern_count_i > CNT_MAX) ? CNT_MAX : pattern_count_i;
  assign out_free = !out_valid_q || out_ready_i;
  assign cmd_ready_o = (state_q == S_IDLE);
  assign pop      = cmd_valid_i && cmd_ready_o;
  assign mem_we   = pop && (cmd_i.op == OP_LOAD);
  assign fill_inc = (fill_q == FILL_FULL) ? fill_q : fill_q + FILL_W'(1);

  // Saturating running total
  assign total_sum = {1'b0, total_q} + (TOTAL_W + 1)'(hits_q);
  assign total_new = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];

  // Sequence commands and the row scan
  always_comb begin
    state_d = state_q;
    win_d   = win_q;
    fill_d  = fill_q;
    total_d = total_q;
    hits_d  = hits_q;
    k_d     = k_q;
    if (rd_valid_q && within_one(win_q, rdata_q)) begin
      hits_d = hits_q + CNT_W'(1);
    end
    case (state_q)
      S_IDLE: begin
        if (pop) begin
          case (cmd_i.op)
            OP_TEXT: begin
              win_d  = {cmd_i.data_byte, win_q[ROW_W-1:BYTE_W]};
              fill_d = fill_inc;
              if (fill_inc == FILL_FULL) begin
                hits_d = '0;
                k_d    = '0;
                state_d = (limit == '0) ? S_DONE : S_SCAN;
              end
            end
            OP_CLEAR: begin
              win_d   = '0;
              fill_d  = '0;
              total_d = '0;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        k_d = k_q + CNT_W'(1);
        if (k_q == limit - CNT_W'(1)) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          total_d = total_new;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      win_q      <= '0;
      fill_q     <= '0;
      total_q    <= '0;
      hits_q     <= '0;
      k_q        <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      win_q      <= win_d;
      fill_q     <= fill_d;
      total_q    <= total_d;
      hits_q     <= hits_d;
      k_q        <= k_d;
      rd_valid_q <= (state_q == S_SCAN);
    end
  end

  // Pattern store: byte write, one row read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[cmd_i.pattern_index][{cmd_i.byte_position, 3'b000} +: BYTE_W] <= cmd_i.data_byte;
    end
    rdata_q <= mem[k_q[ROW_AW-1:0]];
  end

  // Result register: hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && out_free) begin
      out_win_q   <= hits_q;
      out_total_q <= total_new;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign window_matches_o = out_win_q;
  assign running_total_o  = out_total_q;

endmodule

@@ design/multi_pattern_one_mismatch_matcher.sv @@
// ----------------------------------------------------------------------------
// multi_pattern_one_mismatch_matcher: top level
// Counts stored 64-byte patterns within one byte mismatch of a sliding text
// window, with a saturating running total.
//
//   channel   direction  contents
//   in_chan   sink       kind, pattern_index, byte_position, data_byte
//   out_chan  source     window_matches, running_total
//   APB       slave      pattern_count at byte address 0
//
// An accepted item reaches the back end through the registered front queue.
// Loads and clears complete in the idle state of the back end. A text byte
// that leaves the window full steps through the scan, drain and done states
// (only done when the count is zero); the scan reads min(pattern_count, 256)
// rows through the single read port of the pattern store, one row per cycle.
// Reset clears the window, fill, total and pattern_count; the store is not
// cleared. A stalled result holds the back end, while the front queue keeps
// taking up to four items.
// ----------------------------------------------------------------------------
module multi_pattern_one_mismatch_matcher
  import mpm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  mpm_in_if.sink            in_chan,
  mpm_out_if.source         out_chan,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic             cmd_valid;
  logic             cmd_ready;
  cmd_t             cmd;
  logic [CNT_W-1:0] pattern_count_q;
  logic             reg_hit;

  // Configuration register
  assign pready  = 1'b1;
  assign reg_hit = (paddr[APB_AW-1] == REG_PATTERN_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_count_q <= '0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      pattern_count_q <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = reg_hit ? APB_DW'(pattern_count_q) : '0;

  mpm_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_chan.valid),
    .in_ready_o     (in_chan.ready),
    .kind_i         (in_chan.kind),
    .pattern_index_i(in_chan.pattern_index),
    .byte_position_i(in_chan.byte_position),
    .data_byte_i    (in_chan.data_byte),
    .cmd_valid_o    (cmd_valid),
    .cmd_ready_i    (cmd_ready),
    .cmd_o          (cmd)
  );

  mpm_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (cmd_valid),
    .cmd_ready_o     (cmd_ready),
    .cmd_i           (cmd),
    .pattern_count_i (pattern_count_q),
    .out_valid_o     (out_chan.valid),
    .out_ready_i     (out_chan.ready),
    .window_matches_o(out_chan.window_matches),
    .running_total_o (out_chan.running_total)
  );

endmodule

@@ design/mpm_checker.sv @@
// ----------------------------------------------------------------------------
// mpm_checker: port-level checks of the matcher
// Watches the result channel and the configuration port over time.
// ----------------------------------------------------------------------------
module mpm_checker
  import mpm_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [CNT_W-1:0]   window_matches_i,
  input logic [TOTAL_W-1:0] running_total_i,
  input logic               pready_i
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(window_matches_i)
                                    && $stable(running_total_i))
    else $error("result changed while stalled");

  // Total includes the window count of the same result
  a_total_ge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> running_total_i >= TOTAL_W'(window_matches_i))
    else $error("total below window count");

  // Window count never exceeds the store size
  a_win_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> window_matches_i <= CNT_MAX)
    else $error("window count out of range");

  // Configuration port never waits
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready_i)
    else $error("pready low");

endmodule

bind multi_pattern_one_mismatch_matcher mpm_checker u_mpm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_chan.valid),
  .out_ready_i     (out_chan.ready),
  .window_matches_i(out_chan.window_matches),
  .running_total_i (out_chan.running_total),
  .pready_i        (pready)
);
